>>> hdl/mqrb_pkg.sv
package mqrb_pkg;

  // Fixed field widths of the request, response and configuration words
  localparam int OP_W       = 2;
  localparam int QID_W      = 3;
  localparam int DATA_W     = 32;
  localparam int FLAG_W     = 5;
  localparam int CAP_REG_W  = 9;
  localparam int CFG_IDX_W  = 3;

  // Capacity registers exist for the first five queues only
  localparam int NUM_CAP_REGS = 5;
  localparam logic [CAP_REG_W-1:0] CAP_RESET = 9'd256;

  // Operation codes of the request word
  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } op_t;

endpackage

>>> hdl/mqrb_ram.sv
module mqrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1280
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/mqrb_mod.sv
module mqrb_mod #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dvd;
  logic [W-1:0]     dsr;
  logic [W-1:0]     acc;
  logic [W:0]       trial;
  logic [W:0]       dsr_ext;
  logic [W-1:0]     acc_next;

  // Restoring remainder: one dividend bit per cycle, MSB first.
  // acc stays below the divisor, so one subtract per step is enough.
  always_comb begin
    trial    = {acc, dvd[W-1]};
    dsr_ext  = {1'b0, dsr};
    acc_next = (trial >= dsr_ext) ? W'(trial - dsr_ext) : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
        acc  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        acc <= acc_next;
        dvd <= {dvd[W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = acc;

endmodule

>>> hdl/multi_queue_ring_buffer_top.sv
// Multiple circular FIFOs over one shared element RAM.
//
// Request channel (req_valid / req_stall): one word carries operation,
// queue_id, data_in and stabilized. Enqueue, dequeue, or clear of the
// sticky overflow flags. Response channel (rsp_valid / rsp_stall): one
// word per request with success, data_out and overflow_flags.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index selects
// a capacity register, cfg_data is its slot count. Write only when idle.
//
// Response: enqueue, clear and failed operations respond in the cycle
// after acceptance; a successful dequeue responds from the S_READ state
// (registered read of the element RAM). Throughput: 1 word per cycle for
// enqueue and clear unless the response stalls; a dequeue holds off the
// next word until its RAM read is done. An index beyond its queue's capacity
// (after a shrink) wraps in the serial remainder unit; requests wait.
//
// Reset clears heads, tails and flags and sets every capacity to 256; the
// element RAM is not cleared and no word is held off after reset.
// While the response register is full and stalled, req_stall is high;
// a held response never changes.
module multi_queue_ring_buffer_top
  import mqrb_pkg::*;
#(
  parameter int MAX_DEPTH  = 256,
  parameter int ELEM_BITS  = 32,
  parameter int NUM_QUEUES = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [QID_W-1:0]     queue_id,
  input  logic [DATA_W-1:0]    data_in,
  input  logic                 stabilized,
  // response channel
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 success,
  output logic [DATA_W-1:0]    data_out,
  output logic [FLAG_W-1:0]    overflow_flags,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_REG_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_DEPTH);
  localparam int CAP_W  = $clog2(MAX_DEPTH + 1);
  localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int RAM_DEPTH = NUM_QUEUES * MAX_DEPTH;
  localparam int ADDR_W = $clog2(RAM_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_READ} state_t;

  state_t               state;
  logic [CAP_REG_W-1:0] cap_reg [NUM_CAP_REGS];
  logic [IDX_W-1:0]     head [NUM_QUEUES];
  logic [IDX_W-1:0]     tail [NUM_QUEUES];
  logic [FLAG_W-1:0]    ovf;

  // latched request for the slow wrap path
  op_t                  lat_op;
  logic [QID_W-1:0]     lat_q;
  logic [DATA_W-1:0]    lat_data;
  logic                 lat_stab;

  logic                 accept;
  op_t                  src_op;
  logic [QID_W-1:0]     src_q;
  logic [DATA_W-1:0]    src_data;
  logic                 src_stab;
  logic                 q_ok;
  logic                 qop;
  logic [QSEL_W-1:0]    qi;
  logic [IDX_W-1:0]     h;
  logic [IDX_W-1:0]     t;
  logic [IDX_W-1:0]     x;
  logic [CAP_W-1:0]     cap;
  logic [CAP_W-1:0]     inc;
  logic [IDX_W-1:0]     fast_nxt;
  logic [IDX_W-1:0]     nxt;
  logic                 need_mod;
  logic                 mod_start;
  logic                 mod_done;
  logic [CAP_W-1:0]     mod_rem;
  logic                 exec;

  logic                 ex_ok;
  logic [FLAG_W-1:0]    ex_flags;
  logic [FLAG_W-1:0]    flag_bit;
  logic                 head_we;
  logic                 tail_we;
  logic                 mem_we;
  logic                 mem_re;
  logic                 go_read;
  logic [ADDR_W-1:0]    mem_addr;
  logic [ELEM_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  // Request source: live port when idle, latched word on the slow path
  always_comb begin
    if (state == S_MOD) begin
      src_op   = lat_op;
      src_q    = lat_q;
      src_data = lat_data;
      src_stab = lat_stab;
    end else begin
      src_op   = op_t'(operation);
      src_q    = queue_id;
      src_data = data_in;
      src_stab = stabilized;
    end
  end

  // Queue lookup and clamped capacity
  always_comb begin
    int c;
    q_ok = (int'(src_q) < NUM_QUEUES);
    qop  = q_ok && (src_op == OP_ENQ || src_op == OP_DEQ);
    qi   = QSEL_W'(src_q);
    h    = head[qi];
    t    = tail[qi];
    if (int'(src_q) < NUM_CAP_REGS) begin
      c = int'(cap_reg[src_q]);
    end else begin
      c = MAX_DEPTH;
    end
    if (c < 2) begin
      c = 2;
    end
    if (c > MAX_DEPTH) begin
      c = MAX_DEPTH;
    end
    cap = CAP_W'(c);
  end

  // Next index: fast wrap when in range, else serial remainder
  always_comb begin
    x        = (src_op == OP_DEQ) ? h : t;
    inc      = CAP_W'(x) + CAP_W'(1);
    fast_nxt = (inc == cap) ? '0 : IDX_W'(inc);
    need_mod = qop && (inc > cap);
    nxt      = (state == S_MOD) ? IDX_W'(mod_rem) : fast_nxt;
  end

  assign mod_start = accept && need_mod;
  assign exec      = (accept && !need_mod) || (state == S_MOD && mod_done);

  mqrb_mod #(
    .W (CAP_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (inc),
    .divisor  (cap),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Operation decode
  always_comb begin
    for (int i = 0; i < FLAG_W; i++) begin
      flag_bit[i] = (src_q == QID_W'(i));
    end
    ex_ok    = 1'b0;
    ex_flags = ovf;
    head_we  = 1'b0;
    tail_we  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    go_read  = 1'b0;
    if (exec) begin
      unique case (src_op)
        OP_CLR: begin
          ex_flags = '0;
          ex_ok    = 1'b1;
        end
        OP_ENQ: begin
          if (q_ok) begin
            if (h == nxt) begin
              ex_flags = ovf | flag_bit;
            end else begin
              ex_ok = 1'b1;
              if (src_stab) begin
                mem_we  = 1'b1;
                tail_we = 1'b1;
              end
            end
          end
        end
        OP_DEQ: begin
          if (q_ok && h != t) begin
            mem_re  = 1'b1;
            head_we = 1'b1;
            go_read = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Element address: queue base plus slot index
  assign mem_addr = ADDR_W'(ADDR_W'(qi) * ADDR_W'(MAX_DEPTH)) + ADDR_W'(x);

  mqrb_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (ELEM_BITS'(src_data)),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // Request latch for the slow path
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_op   <= op_t'(operation);
      lat_q    <= queue_id;
      lat_data <= data_in;
      lat_stab <= stabilized;
    end
  end

  // Capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CAP_REGS; i++) begin
        cap_reg[i] <= CAP_RESET;
      end
    end else if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_CAP_REGS) begin
      cap_reg[cfg_index] <= cfg_data;
    end
  end

  // Sequencer, queue indices, flags and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ovf       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      ovf <= ex_flags;
      if (head_we) begin
        head[qi] <= nxt;
      end
      if (tail_we) begin
        tail[qi] <= nxt;
      end

      unique case (state)
        S_IDLE: begin
          if (mod_start) begin
            state <= S_MOD;
          end else if (go_read) begin
            state <= S_READ;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= go_read ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (exec && !go_read) begin
        rsp_valid      <= 1'b1;
        success        <= ex_ok;
        data_out       <= '0;
        overflow_flags <= ex_flags;
      end else if (state == S_READ) begin
        rsp_valid      <= 1'b1;
        success        <= 1'b1;
        data_out       <= DATA_W'(mem_rdata);
        overflow_flags <= ovf;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A dequeue that reads the RAM answers with success once S_READ has passed
  a_deq_resp: assert property (@(posedge clk) disable iff (rst)
    go_read |=> ##1 (rsp_valid && success))
    else $error("dequeue response missing");

  // The response register is free while a RAM read is in flight
  a_read_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !rsp_valid)
    else $error("response overwritten by dequeue data");

  // Overflow flags only drop on a clear
  a_flags_sticky: assert property (@(posedge clk) disable iff (rst)
    !(exec && src_op == OP_CLR) |=> (($past(ovf) & ~ovf) == '0))
    else $error("overflow flag lost");

  // The remainder unit finishes only on the slow path
  a_mod_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("unexpected remainder completion");

endmodule
